[sv/wwoc_pkg.sv]
// ----------------------------------------------------------------------------
// wwoc_pkg
// Shared constants, types and character helpers for the whole-word counter.
// ----------------------------------------------------------------------------
package wwoc_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int MIN_PATTERN = 5;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W       = $clog2(MAX_PATTERN);
	localparam int FILL_W      = $clog2(MAX_PATTERN + 2);
	localparam int COUNT_W     = 32;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_ADDR_W  = 5;

	localparam logic [LEN_W-1:0]  LEN_MIN  = LEN_W'(MIN_PATTERN);
	localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_PATTERN);
	localparam logic [FILL_W-1:0] FILL_TOP = FILL_W'(MAX_PATTERN + 1);

	// register indexes, address bits [4:3]
	localparam logic [1:0] REG_PATTERN_LOW    = 2'd0;
	localparam logic [1:0] REG_PATTERN_HIGH   = 2'd1;
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

	localparam logic [7:0] CHAR_SEMI    = 8'h3B;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_TAB     = 8'h09;
	localparam logic [7:0] CHAR_CR      = 8'h0D;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	function automatic logic is_white(input logic [7:0] c);
		return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
		       (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
	endfunction

endpackage

[sv/wwoc_cell.sv]
// ----------------------------------------------------------------------------
// wwoc_cell
// One byte of the recent-text window: holds a byte, passes it on, and
// compares the byte arriving on its input with its pattern byte.
// ----------------------------------------------------------------------------
module wwoc_cell import wwoc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic [7:0] din,
	input  logic [7:0] pat,
	output logic [7:0] dout,
	output logic       eq
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctrl.clear) begin
			byte_q <= '0;
		end else if (ctrl.shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;
	assign eq   = (din == pat);

endmodule

[sv/wwoc_skid.sv]
// ----------------------------------------------------------------------------
// wwoc_skid
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module wwoc_skid import wwoc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [COUNT_W-1:0] push_data,
	output logic               room,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [COUNT_W-1:0] m_axis_tdata
);

	logic               out_valid_q;
	logic [COUNT_W-1:0] out_q;
	logic               skid_valid_q;
	logic [COUNT_W-1:0] skid_q;
	logic               take;

	assign take = out_valid_q & m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	assign room          = ~skid_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

[sv/whole_word_occurrence_counter_core.sv]
// ----------------------------------------------------------------------------
// whole_word_occurrence_counter_core
// Counts whole-word occurrences of a configured pattern in a byte stream.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle while the output buffer has room. Each
// byte moves through a chain of 16 window cells that compare it against the
// pattern in the same cycle. The count beat is registered into a two-entry
// output buffer when the tlast beat is accepted; the slave side stalls only
// while both entries hold unclaimed counts. No clearing pass is needed after
// reset.
module whole_word_occurrence_counter_core import wwoc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // text_byte
	input  logic                  s_axis_tlast,   // end_of_text
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [COUNT_W-1:0]    m_axis_tdata,   // match_count
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [63:0]        pat_low_q;
	logic [63:0]        pat_high_q;
	logic [LEN_W-1:0]   len_q;
	logic               hdr_q;
	logic [FILL_W-1:0]  fill_q;
	logic [IDX_W-1:0]   skip_q;
	logic               pend_q;
	logic [COUNT_W-1:0] total_q;

	logic               hdr_n;
	logic [FILL_W-1:0]  fill_n;
	logic [IDX_W-1:0]   skip_n;
	logic               pend_n;
	logic [1:0]         inc;
	logic               new_pend;

	logic               accept;
	logic               room;
	logic               push;
	logic [COUNT_W-1:0] result;
	logic [7:0]         c_low;
	logic               len_ok;
	logic               hit;
	logic [FILL_W-1:0]  fill_inc;
	logic [7:0]         follow;
	logic [127:0]       pat_all;
	cell_ctrl_t         cell_ctrl;

	logic [7:0]         cell_din  [MAX_PATTERN];
	logic [7:0]         cell_dout [MAX_PATTERN];
	logic [7:0]         cell_pat  [MAX_PATTERN];
	logic               cell_eq   [MAX_PATTERN];

	function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
	                                               input logic [1:0] b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + (COUNT_W + 1)'(b);
		return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
	endfunction

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			len_q      <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[4:3])
				REG_PATTERN_LOW:    pat_low_q  <= pwdata;
				REG_PATTERN_HIGH:   pat_high_q <= pwdata;
				REG_PATTERN_LENGTH: len_q      <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_PATTERN_LOW:    prdata = pat_low_q;
			REG_PATTERN_HIGH:   prdata = pat_high_q;
			REG_PATTERN_LENGTH: prdata = CFG_DATA_W'(len_q);
			default:            prdata = '0;
		endcase
	end

	// window cell chain
	assign accept  = s_axis_tvalid & s_axis_tready;
	assign c_low   = to_lower(s_axis_tdata);
	assign pat_all = {pat_high_q, pat_low_q};

	assign cell_ctrl.shift = accept & ~s_axis_tlast & ~hdr_q & (c_low != CHAR_SEMI);
	assign cell_ctrl.clear = accept & s_axis_tlast;

	genvar k;
	generate
		for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
			logic [IDX_W-1:0] pidx;
			assign pidx = IDX_W'(len_q - LEN_W'(1) - LEN_W'(k));
			assign cell_pat[k] = pat_all[pidx*8 +: 8];
			if (k == 0) begin : g_head
				assign cell_din[k] = c_low;
			end else begin : g_link
				assign cell_din[k] = cell_dout[k-1];
			end
			wwoc_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (cell_ctrl),
				.din    (cell_din[k]),
				.pat    (cell_pat[k]),
				.dout   (cell_dout[k]),
				.eq     (cell_eq[k])
			);
		end
	endgenerate

	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (LEN_W'(i) < len_q) begin
				hit = hit & cell_eq[i];
			end
		end
	end

	assign len_ok   = (len_q >= LEN_MIN) && (len_q <= LEN_MAX);
	assign fill_inc = (fill_q == FILL_TOP) ? fill_q : fill_q + FILL_W'(1);
	assign follow   = cell_dout[IDX_W'(len_q - LEN_W'(1))];

	// field and match control
	always_comb begin
		hdr_n    = hdr_q;
		fill_n   = fill_q;
		skip_n   = skip_q;
		pend_n   = pend_q;
		inc      = 2'd0;
		new_pend = 1'b0;
		push     = 1'b0;
		if (accept) begin
			if (s_axis_tlast) begin
				push   = 1'b1;
				hdr_n  = 1'b1;
				fill_n = '0;
				skip_n = '0;
				pend_n = 1'b0;
			end else if (hdr_q) begin
				if (s_axis_tdata == CHAR_NEWLINE) begin
					hdr_n = 1'b0;
				end
			end else begin
				inc    = {1'b0, pend_q & (is_white(c_low) | is_punct(c_low))};
				pend_n = 1'b0;
				if (c_low == CHAR_SEMI) begin
					fill_n = '0;
					skip_n = '0;
				end else begin
					fill_n = fill_inc;
					if (skip_q != '0) begin
						skip_n = skip_q - IDX_W'(1);
					end else if (len_ok && (fill_inc >= FILL_W'(len_q)) && hit) begin
						new_pend = (fill_inc == FILL_W'(len_q)) | is_white(follow);
						skip_n   = IDX_W'(len_q - LEN_W'(1));
					end
					if (c_low == CHAR_NEWLINE) begin
						inc    = inc + {1'b0, new_pend};
						fill_n = '0;
						skip_n = '0;
					end else begin
						pend_n = new_pend;
					end
				end
			end
		end
	end

	assign result = sat_add(total_q, {1'b0, pend_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q   <= 1'b1;
			fill_q  <= '0;
			skip_q  <= '0;
			pend_q  <= 1'b0;
			total_q <= '0;
		end else begin
			hdr_q  <= hdr_n;
			fill_q <= fill_n;
			skip_q <= skip_n;
			pend_q <= pend_n;
			if (push) begin
				total_q <= '0;
			end else begin
				total_q <= sat_add(total_q, inc);
			end
		end
	end

	// result beats
	wwoc_skid u_skid (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.push_data     (result),
		.room          (room),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	assign s_axis_tready = room;

endmodule

[tb/sv/wwoc_count_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwoc_count_check
// Watches the register port and both stream sides of the whole-word counter,
// keeps its own copy of the pattern and of the text state, predicts the count
// for every end-of-text beat and compares each count beat against the oldest
// prediction. Failures are counted and handed to the top.
// ----------------------------------------------------------------------------
module wwoc_count_check import wwoc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,
	input  logic                  s_axis_tlast,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [COUNT_W-1:0]    m_axis_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	input  logic                  pready,
	output int unsigned           error_count,
	output int unsigned           pending_counts
);

	localparam int WIN = MAX_PATTERN + 1;

	logic [63:0]        pat_low;
	logic [63:0]        pat_high;
	logic [4:0]         pat_len;
	logic               in_header;
	logic [7:0]         recent [WIN];
	int unsigned        fill;
	int unsigned        skip;
	logic               word_open;
	logic [COUNT_W-1:0] found;
	logic [COUNT_W-1:0] expected_counts [$];
	int unsigned        mismatches;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_mark(input logic [7:0] c);
		return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
		       (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
	endfunction

	function automatic logic [7:0] pattern_byte(input int unsigned i);
		logic [127:0] whole;
		whole = {pat_high, pat_low};
		return whole[8*i +: 8];
	endfunction

	function automatic logic window_hit(input int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			if (recent[len - 1 - i] != pattern_byte(i))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic bump_found();
		if (found != '1)
			found = found + 1;
	endtask

	task automatic clear_text();
		in_header = 1'b1;
		foreach (recent[i])
			recent[i] = 8'h00;
		fill = 0;
		skip = 0;
		word_open = 1'b0;
		found = '0;
	endtask

	task automatic report_fault(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	task automatic take_beat(input logic [7:0] raw, input logic eot);
		logic [7:0]  c;
		int unsigned len;
		c = raw;
		len = pat_len;
		if (eot) begin
			if (word_open)
				bump_found();
			expected_counts.push_back(found);
			clear_text();
			return;
		end
		if (in_header) begin
			if (c == CHAR_NEWLINE)
				in_header = 1'b0;
			return;
		end
		if (c >= 8'h41 && c <= 8'h5A)
			c = c + 8'h20;
		if (word_open) begin
			if (is_space(c) || is_mark(c))
				bump_found();
			word_open = 1'b0;
		end
		if (c == CHAR_SEMI) begin
			fill = 0;
			skip = 0;
			return;
		end
		for (int unsigned i = WIN - 1; i > 0; i--)
			recent[i] = recent[i - 1];
		recent[0] = c;
		if (fill < WIN)
			fill++;
		if (skip > 0) begin
			skip--;
		end else if (len >= MIN_PATTERN && len <= MAX_PATTERN && fill >= len &&
		             window_hit(len)) begin
			if (fill == len || is_space(recent[len]))
				word_open = 1'b1;
			skip = len - 1;
		end
		if (c == CHAR_NEWLINE) begin
			if (word_open)
				bump_found();
			word_open = 1'b0;
			fill = 0;
			skip = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low = '0;
			pat_high = '0;
			pat_len = '0;
			clear_text();
			expected_counts.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:3])
					REG_PATTERN_LOW:    pat_low = pwdata;
					REG_PATTERN_HIGH:   pat_high = pwdata;
					REG_PATTERN_LENGTH: pat_len = pwdata[4:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_counts.size() == 0) begin
					report_fault($sformatf("unexpected count beat: got %0d", m_axis_tdata));
				end else if (m_axis_tdata !== expected_counts[0]) begin
					report_fault($sformatf("match_count mismatch: expected %0d, got %0d",
						expected_counts[0], m_axis_tdata));
					void'(expected_counts.pop_front());
				end else begin
					void'(expected_counts.pop_front());
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				take_beat(s_axis_tdata, s_axis_tlast);
		end
		error_count <= mismatches;
		pending_counts <= expected_counts.size();
	end

endmodule

[tb/sv/whole_word_occurrence_counter_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whole_word_occurrence_counter_core_test
// Drives texts into the whole-word counter in bursts with random gaps while
// the count side stalls on its own pattern. Each phase loads a new pattern
// and length over the register port while the block is idle; a separate
// check module predicts and compares the counts, and the verdict is printed.
// ----------------------------------------------------------------------------
module whole_word_occurrence_counter_core_test;
	import wwoc_pkg::*;

	localparam int ITEM_TARGET  = 1600;
	localparam int TEXT_TARGET  = 40;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = 8'h00;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [COUNT_W-1:0]    m_axis_tdata;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	int unsigned error_count;
	int unsigned pending_counts;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned texts_sent = 0;
	int unsigned burst_left = 0;
	bit          gap_on = 1'b1;
	int unsigned phase;
	logic [7:0]  text_bytes [$];
	logic [127:0] cur_pattern;
	int unsigned cur_len;
	stall_mode_t stall_mode = STALL_NONE;
	logic [7:0]  stall_clock = 8'h00;

	always #6 clk = ~clk;

	whole_word_occurrence_counter_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	wwoc_count_check i_count_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.error_count    (error_count),
		.pending_counts (pending_counts)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		stall_clock <= stall_clock + 8'd1;
		if (stall_clock == 8'hFF)
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_NONE:     m_axis_tready <= 1'b1;
			STALL_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
			STALL_HEAVY:    m_axis_tready <= ($urandom_range(0, 7) == 0);
			STALL_PERIODIC: m_axis_tready <= (stall_clock[2:0] != 3'd5);
			default:        m_axis_tready <= 1'b1;
		endcase
	end

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_setup(input logic [127:0] pat, input int unsigned len);
		logic [63:0] len_word;
		len_word = {$urandom, $urandom};
		len_word[4:0] = 5'(len);
		write_reg(REG_PATTERN_LOW, pat[63:0]);
		write_reg(REG_PATTERN_HIGH, pat[127:64]);
		write_reg(REG_PATTERN_LENGTH, len_word);
		cur_pattern = pat;
		cur_len = len;
	endtask

	task automatic pick_setup(input int unsigned step);
		logic [127:0] pat;
		logic [7:0]   rep;
		logic [7:0]   b;
		int unsigned  len;
		int unsigned  kind;
		pat = {$urandom, $urandom, $urandom, $urandom};
		rep = 8'h61 + 8'($urandom_range(0, 25));
		kind = $urandom_range(0, 9);
		if (step == 0) begin
			pat = '1;
			len = MAX_PATTERN;
		end else if (step == 1) begin
			pat = '0;
			len = 0;
		end else begin
			if (step == 2)
				len = MIN_PATTERN - 1;
			else if (step == 3)
				len = 20;
			else if (step == 4)
				len = MIN_PATTERN;
			else if (step == 5)
				len = MAX_PATTERN;
			else if ($urandom_range(0, 7) == 0)
				len = $urandom_range(0, 20);
			else if ($urandom_range(0, 2) == 0)
				len = $urandom_range(5, 7);
			else
				len = $urandom_range(5, 16);
			for (int unsigned i = 0; i < len && i < MAX_PATTERN; i++) begin
				if (kind == 7)
					b = 8'($urandom);
				else if (kind == 8)
					b = rep;
				else
					b = 8'h61 + 8'($urandom_range(0, 25));
				if (kind == 9 && $urandom_range(0, 4) == 0)
					b = b - CASE_OFFSET;
				pat[8*i +: 8] = b;
			end
		end
		load_setup(pat, len);
	endtask

	task automatic emit_pattern(input int unsigned n, input bit broken);
		logic [7:0] b;
		for (int unsigned i = 0; i < n; i++) begin
			b = cur_pattern[8*i +: 8];
			if (b >= 8'h61 && b <= 8'h7A && $urandom_range(0, 3) == 0)
				b = b - CASE_OFFSET;
			if (broken && i == n - 1)
				b = b ^ 8'h01;
			text_bytes.push_back(b);
		end
	endtask

	task automatic append_string(input string s);
		for (int i = 0; i < s.len(); i++)
			text_bytes.push_back(s[i]);
	endtask

	task automatic compose_text();
		string       marks;
		int unsigned tokens;
		int unsigned pick;
		int unsigned plen;
		logic [7:0]  b;
		marks = "!\"#$%&'()*+,-./:;<=>?@[\\]^_`{|}~";
		text_bytes.delete();
		plen = (cur_len == 0) ? MIN_PATTERN :
		       ((cur_len > MAX_PATTERN) ? MAX_PATTERN : cur_len);
		repeat ($urandom_range(0, 4)) begin
			b = 8'($urandom);
			text_bytes.push_back((b == CHAR_NEWLINE) ? CHAR_SPACE : b);
		end
		if ($urandom_range(0, 15) != 0)
			text_bytes.push_back(CHAR_NEWLINE);
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(4, 40))
				text_bytes.push_back(8'($urandom));
			return;
		end
		tokens = $urandom_range(2, 14);
		for (int unsigned k = 0; k < tokens; k++) begin
			pick = $urandom_range(0, 19);
			if (pick <= 6) begin
				emit_pattern(plen, 1'b0);
			end else if (pick <= 8) begin
				emit_pattern(plen - 1, 1'b0);
			end else if (pick == 9) begin
				emit_pattern(plen, 1'b1);
			end else if (pick == 10) begin
				emit_pattern(plen, 1'b0);
				emit_pattern(plen, 1'b0);
			end else if (pick <= 12) begin
				repeat ($urandom_range(1, 6))
					text_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
			end else if (pick <= 14) begin
				text_bytes.push_back(CHAR_SPACE);
			end else if (pick == 15) begin
				text_bytes.push_back(8'($urandom_range(9, 13)));
			end else if (pick == 16) begin
				text_bytes.push_back(CHAR_SEMI);
			end else if (pick == 17) begin
				text_bytes.push_back(CHAR_NEWLINE);
			end else if (pick == 18) begin
				text_bytes.push_back(marks[$urandom_range(0, marks.len() - 1)]);
			end else begin
				text_bytes.push_back(8'($urandom));
			end
		end
	endtask

	task automatic push_item(input logic [7:0] b, input logic eot);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = gap_on ? $urandom_range(0, 12) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_axis_tdata <= b;
		s_axis_tlast <= eot;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic send_text();
		foreach (text_bytes[i])
			push_item(text_bytes[i], 1'b0);
		push_item(8'($urandom), 1'b1);
		texts_sent++;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_counts != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: "hello", case folding, field ends, extreme bytes
		load_setup({64'h0, 64'h0000_006F_6C6C_6568}, MIN_PATTERN);
		push_item(8'hA5, 1'b1);
		text_bytes.delete();
		append_string("\nHELLO\thello;");
		text_bytes.push_back(8'h00);
		text_bytes.push_back(8'hFF);
		append_string("hello\n");
		send_text();

		phase = 0;
		while (items_sent < ITEM_TARGET || texts_sent < TEXT_TARGET) begin
			settle();
			pick_setup(phase);
			phase++;
			gap_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(2, 5)) begin
				compose_text();
				send_text();
			end
		end
		settle();

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
